// File: rtl/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

	typedef struct packed {
		logic [7:0] text_char;
		logic       final_char;
	} in_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       group_end;
		logic       end_of_data;
		logic       bad_char;
	} out_t;

	// one closed group, handed from front to back
	typedef struct packed {
		logic [23:0] word;
		logic        last;
		logic        bad;
	} grp_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	localparam logic [1:0] FILL_FULL = 2'd3;
	localparam logic [1:0] LAST_BYTE = 2'd2;
	localparam logic [1:0] Q_DEPTH   = 2'd2;

	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_Z = 8'h5A;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_Z = 8'h7A;
	localparam logic [7:0] CH_D0   = 8'h30;
	localparam logic [7:0] CH_D9   = 8'h39;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_USCR = 8'h5F;

	// map one URL-safe character to its six-bit value; anything else is zero, invalid
	function automatic sextet_t char_value(input logic [7:0] c);
		sextet_t r;
		logic [7:0] d;
		r.valid = 1'b1;
		r.value = 6'd0;
		d       = 8'd0;
		if (c >= CH_UP_A && c <= CH_UP_Z) begin
			d = c - CH_UP_A;
		end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
			d = c - CH_LO_A + 8'd26;
		end else if (c >= CH_D0 && c <= CH_D9) begin
			d = c - CH_D0 + 8'd52;
		end else if (c == CH_DASH) begin
			d = 8'd62;
		end else if (c == CH_USCR) begin
			d = 8'd63;
		end else begin
			r.valid = 1'b0;
		end
		r.value = d[5:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// File: rtl/base64url_stream_decoder_unit.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data  (text_char, final_char)
// out     | output    | out_valid / out_ready | out_data (data_byte, group_end,
//         |           |                       |           end_of_data, bad_char)
// One character is taken per cycle while the two-entry group queue has room.
// Each group closed by its fourth or final character leaves three bytes, one per
// cycle while out_ready is high, from the serializer register; the first is valid
// only once the group has passed the queue and been loaded into that register.
// Sustained input rate is bounded by three output bytes per closed group. Reset clears
// group fill, queue and serializer. Out stalls fill the queue, then drop in_ready.
`default_nettype none
module base64url_stream_decoder_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire b64d_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output b64d_pkg::out_t      out_data
);
	import b64d_pkg::*;

	logic q_full;
	logic push;
	grp_t push_grp;
	logic q_valid;
	logic pop;
	grp_t q_grp;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.push_grp (push_grp)
	);

	b64d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.full     (q_full),
		.q_valid  (q_valid),
		.pop      (pop),
		.q_grp    (q_grp)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_grp     (q_grp),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// File: rtl/b64d_front.sv
`default_nettype none
module b64d_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire b64d_pkg::in_t in_data,
	input  wire logic         q_full,
	output logic              push,
	output b64d_pkg::grp_t    push_grp
);
	import b64d_pkg::*;

	logic [17:0] sextets_q;
	logic [1:0]  fill_q;
	logic        bad_q;
	sextet_t     sx;
	logic        xfer;
	logic        close;
	logic        bad_now;

	assign sx       = char_value(in_data.text_char);
	assign in_ready = !q_full;
	assign xfer     = in_valid && in_ready;
	assign close    = (fill_q == FILL_FULL) || in_data.final_char;
	assign bad_now  = bad_q || !sx.valid;
	assign push     = xfer && close;

	// left-align the held values, zero-fill a short group
	always_comb begin
		push_grp.last = in_data.final_char;
		push_grp.bad  = bad_now;
		case (fill_q)
			2'd0:    push_grp.word = {sx.value, 18'd0};
			2'd1:    push_grp.word = {sextets_q[5:0], sx.value, 12'd0};
			2'd2:    push_grp.word = {sextets_q[11:0], sx.value, 6'd0};
			default: push_grp.word = {sextets_q, sx.value};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sextets_q <= '0;
			fill_q    <= '0;
			bad_q     <= 1'b0;
		end else if (xfer) begin
			if (close) begin
				sextets_q <= '0;
				fill_q    <= '0;
				bad_q     <= 1'b0;
			end else begin
				sextets_q <= {sextets_q[11:0], sx.value};
				fill_q    <= fill_q + 2'd1;
				bad_q     <= bad_now;
			end
		end
	end

	a_close_empties: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (fill_q == 2'd0) && !bad_q)
		else $error("group state not cleared after close");

endmodule
`default_nettype wire

// File: rtl/b64d_queue.sv
`default_nettype none
module b64d_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire b64d_pkg::grp_t push_grp,
	output logic                full,
	output logic                q_valid,
	input  wire logic           pop,
	output b64d_pkg::grp_t      q_grp
);
	import b64d_pkg::*;

	grp_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == Q_DEPTH);
	assign q_valid = (cnt_q != 2'd0);
	assign q_grp   = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && !q_valid))
		else $error("queue overrun or underrun");

endmodule
`default_nettype wire

// File: rtl/b64d_back.sv
`default_nettype none
module b64d_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_valid,
	input  wire b64d_pkg::grp_t q_grp,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output b64d_pkg::out_t      out_data
);
	import b64d_pkg::*;

	grp_t       grp_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       xfer;
	logic       at_last;

	assign xfer      = busy_q && out_ready;
	assign at_last   = (idx_q == LAST_BYTE);
	assign pop       = q_valid && (!busy_q || (xfer && at_last));
	assign out_valid = busy_q;

	always_comb begin
		case (idx_q)
			2'd0:    out_data.data_byte = grp_q.word[23:16];
			2'd1:    out_data.data_byte = grp_q.word[15:8];
			default: out_data.data_byte = grp_q.word[7:0];
		endcase
		out_data.group_end   = at_last;
		out_data.end_of_data = at_last && grp_q.last;
		out_data.bad_char    = grp_q.bad;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= q_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (xfer) begin
			if (at_last) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd3)
		else $error("byte index out of range");

	a_byte_advance: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !at_last |=> busy_q && (idx_q == $past(idx_q) + 2'd1))
		else $error("byte index did not advance after transfer");

	a_end_on_third: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.end_of_data |-> out_data.group_end)
		else $error("end of data off the third byte");

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
module testbench;

	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	b64d_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	b64d_pkg::out_t out_data;

	b64d_pkg::in_t char_queue[$];
	b64d_pkg::out_t byte_queue[$];

	// decoder state as the block should hold it
	logic [17:0] grp_buf = '0;
	logic [1:0] grp_fill = '0;
	logic grp_bad = 1'b0;

	int sent_count = 0;
	int errors = 0;
	logic steady;

	// no idling on either side while this window of characters goes through
	assign steady = (sent_count >= 140 && sent_count < 220);

	base64url_stream_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// {valid, value} of one character
	function automatic logic [6:0] sextet_of(logic [7:0] c);
		if (c >= "A" && c <= "Z") begin
			return {1'b1, 6'(c - "A")};
		end else if (c >= "a" && c <= "z") begin
			return {1'b1, 6'(c - "a" + 26)};
		end else if (c >= "0" && c <= "9") begin
			return {1'b1, 6'(c - "0" + 52)};
		end else if (c == "-") begin
			return {1'b1, 6'd62};
		end else if (c == "_") begin
			return {1'b1, 6'd63};
		end
		return 7'd0;
	endfunction

	// advance the group state by one character and queue the bytes it closes
	task automatic decode_char(b64d_pkg::in_t item);
		logic [6:0] sx;
		int count;
		logic bad;
		logic [23:0] word;
		b64d_pkg::out_t r;
		sx = sextet_of(item.text_char);
		count = int'(grp_fill) + 1;
		bad = grp_bad | ~sx[6];
		if (count < 4 && !item.final_char) begin
			grp_buf = {grp_buf[11:0], sx[5:0]};
			grp_fill = 2'(count);
			grp_bad = bad;
		end else begin
			word = {grp_buf, sx[5:0]};
			word = word << (6 * (4 - count));
			for (int k = 0; k < 3; k++) begin
				r.data_byte = word[23 - 8 * k -: 8];
				r.group_end = (k == 2);
				r.end_of_data = (k == 2) && item.final_char;
				r.bad_char = bad;
				byte_queue.push_back(r);
			end
			grp_buf = '0;
			grp_fill = '0;
			grp_bad = 1'b0;
		end
	endtask

	task automatic report_mismatch(string msg);
		$display("%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_byte(b64d_pkg::out_t got);
		b64d_pkg::out_t want;
		if (byte_queue.size() == 0) begin
			report_mismatch($sformatf("unexpected output transfer, byte %02h", got.data_byte));
		end else begin
			want = byte_queue.pop_front();
			if (got.data_byte !== want.data_byte)
				report_mismatch($sformatf("data_byte %02h, want %02h",
					got.data_byte, want.data_byte));
			if (got.group_end !== want.group_end)
				report_mismatch($sformatf("group_end %b, want %b",
					got.group_end, want.group_end));
			if (got.end_of_data !== want.end_of_data)
				report_mismatch($sformatf("end_of_data %b, want %b",
					got.end_of_data, want.end_of_data));
			if (got.bad_char !== want.bad_char)
				report_mismatch($sformatf("bad_char %b, want %b",
					got.bad_char, want.bad_char));
		end
	endtask

	task automatic add_text(string s, bit ends);
		b64d_pkg::in_t item;
		for (int i = 0; i < s.len(); i++) begin
			item.text_char = s[i];
			item.final_char = ends && (i == s.len() - 1);
			char_queue.push_back(item);
		end
	endtask

	// driver: hold a stalled transfer, otherwise present the next character or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && in_ready)
				decode_char(in_data);
			if (!in_valid || in_ready) begin
				if (char_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 29)) begin
					in_data <= char_queue.pop_front();
					in_valid <= 1'b1;
					sent_count <= sent_count + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_byte(out_data);
			out_ready <= steady || ($urandom_range(0, 99) >= 29);
		end
	end

	initial begin
		b64d_pkg::in_t item;
		int made;
		int len;
		int pick;

		add_text("AZaz", 1'b0);
		add_text("09-_", 1'b0);
		add_text("____", 1'b0);
		add_text("@[`{", 1'b0);
		// bad characters with final on the fourth character of the group
		add_text("/:=", 1'b0);
		item.text_char = 8'hFF;
		item.final_char = 1'b1;
		char_queue.push_back(item);
		// short final groups of one, two and three characters
		add_text("Q", 1'b1);
		add_text("Qw", 1'b1);
		add_text("Qw-", 1'b1);

		made = 0;
		while (made < 310) begin
			pick = $urandom_range(0, 99);
			if (pick < 85) begin
				len = $urandom_range(1, 16);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 99) < 5)
						item.text_char = 8'($urandom_range(0, 255));
					else
						item.text_char = ALPHABET[$urandom_range(0, 63)];
					item.final_char = (i == len - 1);
					char_queue.push_back(item);
				end
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) begin
					item.text_char = 8'($urandom_range(0, 255));
					item.final_char = 1'($urandom_range(0, 1));
					char_queue.push_back(item);
				end
			end
			made += len;
		end
		// close whatever group the noise left open
		add_text("A", 1'b1);

		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (char_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (byte_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#3_600_000;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: files.f
rtl/b64d_pkg.sv
rtl/b64d_front.sv
rtl/b64d_queue.sv
rtl/b64d_back.sv
rtl/base64url_stream_decoder_unit.sv
sim/testbench.sv
